FILE: rtl/depth_sorted_display_table_defines.svh
// Assertion macros for the depth-sorted display table.
`ifndef DEPTH_SORTED_DISPLAY_TABLE_DEFINES_SVH
`define DEPTH_SORTED_DISPLAY_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked with reset masked.
`define DSDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, also in reset.
`define DSDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DSDT_ASSERT(label, prop, msg)
`define DSDT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/dsdt_pkg.sv
// Shared types and codes of the depth-sorted display table.
package dsdt_pkg;

  localparam int unsigned DATA_W = 16;

  typedef enum logic [1:0] {
    REQ_PLACE  = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_LIST   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    STAT_INSERTED = 3'd0,
    STAT_REPLACED = 3'd1,
    STAT_NOOBJ    = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_REMOVED  = 3'd4,
    STAT_NOTFOUND = 3'd5,
    STAT_ENTRY    = 3'd6,
    STAT_EMPTY    = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LIST = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_PROBE   = 3'd1,
    CELL_INSERT  = 3'd2,
    CELL_REPLACE = 3'd3,
    CELL_REMOVE  = 3'd4,
    CELL_ROTATE  = 3'd5
  } cell_op_e;

  typedef struct packed {
    logic [DATA_W-1:0] depth;
    logic [DATA_W-1:0] char_h;
    logic [DATA_W-1:0] matrix_h;
    logic [DATA_W-1:0] cxform_h;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   entry;
  } cell_cmd_t;

  typedef struct packed {
    logic occupied;
    logic at_count;
    logic at_last;
  } cell_pos_t;

endpackage

FILE: rtl/dsdt_cell.sv
// One slot of the sorted table: holds an entry and shifts with its neighbors.
module dsdt_cell (
  input  logic               clk_i,
  input  dsdt_pkg::cell_cmd_t cmd_i,
  input  dsdt_pkg::cell_pos_t pos_i,
  input  dsdt_pkg::entry_t   left_entry_i,
  input  logic               left_gt_i,
  input  dsdt_pkg::entry_t   right_entry_i,
  input  dsdt_pkg::entry_t   wrap_entry_i,
  output dsdt_pkg::entry_t   entry_o,
  output logic               match_o,
  output logic               gt_o
);

  dsdt_pkg::entry_t entry_q, entry_d;
  logic             match_q, match_d;
  logic             ge_q, ge_d;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    ge_d    = ge_q;
    case (cmd_i.op)
      dsdt_pkg::CELL_PROBE: begin
        match_d = pos_i.occupied && (entry_q.depth == cmd_i.entry.depth);
        ge_d    = pos_i.occupied && (entry_q.depth >= cmd_i.entry.depth);
      end
      dsdt_pkg::CELL_INSERT: begin
        // the run of deeper entries moves one slot right; the new one lands at its head
        if (left_gt_i) begin
          entry_d = left_entry_i;
        end else if (gt_o || pos_i.at_count) begin
          entry_d = cmd_i.entry;
        end
      end
      dsdt_pkg::CELL_REPLACE: begin
        if (match_q) begin
          entry_d = cmd_i.entry;
        end
      end
      dsdt_pkg::CELL_REMOVE: begin
        if (ge_q) begin
          entry_d = right_entry_i;
        end
      end
      dsdt_pkg::CELL_ROTATE: begin
        entry_d = pos_i.at_last ? wrap_entry_i : right_entry_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
    ge_q    <= ge_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign gt_o    = ge_q && !match_q;

endmodule

FILE: rtl/depth_sorted_display_table.sv
// Top level of the depth-sorted display table: request control and cell chain.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o | req_type, depth, char/matrix/cxform
//  out     | output    | out_valid_o/out_stall_i | status, depth, handles, last
//
// Place and remove first probe every cell against the depth, then merge,
// decide and shift the chain. A list emits one entry per cycle while the
// output is free (an empty table gives a single empty report), rotating the
// chain through cell 0.
// Reset clears the entry count and the control; cell contents stay undefined.
// A stalled output holds the result register and the block waits for it.
module depth_sorted_display_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] depth_i,
  input  logic [15:0] char_handle_i,
  input  logic [15:0] matrix_handle_i,
  input  logic [15:0] cxform_handle_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] out_depth_o,
  output logic [15:0] out_char_o,
  output logic [15:0] out_matrix_o,
  output logic [15:0] out_cxform_o,
  output logic        last_o
);

`include "depth_sorted_display_table_defines.svh"

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  dsdt_pkg::state_e    state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    list_q, list_d;
  dsdt_pkg::req_e      req_q;
  dsdt_pkg::entry_t    req_ent_q;

  logic                out_valid_q, out_valid_d;
  dsdt_pkg::status_e   out_status_q, out_status_d;
  dsdt_pkg::entry_t    out_ent_q, out_ent_d;
  logic                out_last_q, out_last_d;

  dsdt_pkg::cell_cmd_t cmd;
  dsdt_pkg::entry_t    cell_entry [ENTRIES];
  logic [ENTRIES-1:0]  cell_match;
  logic [ENTRIES-1:0]  cell_gt;
  dsdt_pkg::entry_t    sel;
  dsdt_pkg::entry_t    merged;
  logic                found;
  logic                in_accept;
  logic                out_free;

  assign in_stall_o = (state_q != dsdt_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // --- cell chain ---
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    dsdt_pkg::cell_pos_t pos;
    dsdt_pkg::entry_t    left_ent;
    dsdt_pkg::entry_t    right_ent;
    logic                left_gt;

    assign pos.occupied = (count_q > CNT_W'(i));
    assign pos.at_count = (count_q == CNT_W'(i));
    assign pos.at_last  = (count_q == CNT_W'(i + 1));

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = cell_entry[i-1];
      assign left_gt  = cell_gt[i-1];
    end
    if (i == ENTRIES - 1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = cell_entry[i+1];
    end

    dsdt_cell u_cell (
      .clk_i         (clk_i),
      .cmd_i         (cmd),
      .pos_i         (pos),
      .left_entry_i  (left_ent),
      .left_gt_i     (left_gt),
      .right_entry_i (right_ent),
      .wrap_entry_i  (cell_entry[0]),
      .entry_o       (cell_entry[i]),
      .match_o       (cell_match[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // at most one cell matches, so an AND-OR picks it
  always_comb begin
    sel = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cell_match[i]) begin
        sel = sel | cell_entry[i];
      end
    end
  end

  assign found           = |cell_match;
  assign merged.depth    = req_ent_q.depth;
  assign merged.char_h   = (req_ent_q.char_h != '0) ? req_ent_q.char_h : sel.char_h;
  assign merged.matrix_h = (req_ent_q.matrix_h != '0) ? req_ent_q.matrix_h : sel.matrix_h;
  assign merged.cxform_h = (req_ent_q.cxform_h != '0) ? req_ent_q.cxform_h : sel.cxform_h;

  // --- control ---
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    list_d       = list_q;
    cmd.op       = dsdt_pkg::CELL_HOLD;
    cmd.entry    = merged;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_ent_d    = out_ent_q;
    out_last_d   = out_last_q;

    case (state_q)
      dsdt_pkg::ST_IDLE: begin
        cmd.entry.depth = depth_i;
        if (in_accept) begin
          case (dsdt_pkg::req_e'(req_type_i))
            dsdt_pkg::REQ_PLACE, dsdt_pkg::REQ_REMOVE: begin
              cmd.op  = dsdt_pkg::CELL_PROBE;
              state_d = dsdt_pkg::ST_EXEC;
            end
            dsdt_pkg::REQ_LIST: begin
              list_d  = '0;
              state_d = dsdt_pkg::ST_LIST;
            end
            default: begin
              // drop unused request codes
            end
          endcase
        end
      end

      dsdt_pkg::ST_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          state_d     = dsdt_pkg::ST_IDLE;
          if (req_q == dsdt_pkg::REQ_PLACE) begin
            out_ent_d = merged;
            if (merged.char_h == '0) begin
              out_status_d = dsdt_pkg::STAT_NOOBJ;
            end else if (found) begin
              out_status_d = dsdt_pkg::STAT_REPLACED;
              cmd.op       = dsdt_pkg::CELL_REPLACE;
            end else if (count_q == CNT_W'(ENTRIES)) begin
              out_status_d = dsdt_pkg::STAT_FULL;
            end else begin
              out_status_d = dsdt_pkg::STAT_INSERTED;
              cmd.op       = dsdt_pkg::CELL_INSERT;
              count_d      = count_q + CNT_W'(1);
            end
          end else begin
            out_ent_d.depth = req_ent_q.depth;
            if (found) begin
              out_status_d       = dsdt_pkg::STAT_REMOVED;
              out_ent_d.char_h   = merged.char_h;
              out_ent_d.matrix_h = sel.matrix_h;
              out_ent_d.cxform_h = sel.cxform_h;
              cmd.op             = dsdt_pkg::CELL_REMOVE;
              count_d            = count_q - CNT_W'(1);
            end else begin
              out_status_d       = dsdt_pkg::STAT_NOTFOUND;
              out_ent_d.char_h   = '0;
              out_ent_d.matrix_h = '0;
              out_ent_d.cxform_h = '0;
            end
          end
        end
      end

      dsdt_pkg::ST_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (count_q == '0) begin
            out_status_d = dsdt_pkg::STAT_EMPTY;
            out_ent_d    = '0;
            out_last_d   = 1'b1;
            state_d      = dsdt_pkg::ST_IDLE;
          end else begin
            // emit the head, then rotate the occupied run left by one
            out_status_d = dsdt_pkg::STAT_ENTRY;
            out_ent_d    = cell_entry[0];
            out_last_d   = (list_q == count_q - CNT_W'(1));
            cmd.op       = dsdt_pkg::CELL_ROTATE;
            list_d       = list_q + CNT_W'(1);
            if (list_q == count_q - CNT_W'(1)) begin
              state_d = dsdt_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = dsdt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsdt_pkg::ST_IDLE;
      count_q     <= '0;
      list_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      list_q      <= list_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q              <= dsdt_pkg::req_e'(req_type_i);
      req_ent_q.depth    <= depth_i;
      req_ent_q.char_h   <= char_handle_i;
      req_ent_q.matrix_h <= matrix_handle_i;
      req_ent_q.cxform_h <= cxform_handle_i;
    end
    out_status_q <= out_status_d;
    out_ent_q    <= out_ent_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign out_depth_o  = out_ent_q.depth;
  assign out_char_o   = out_ent_q.char_h;
  assign out_matrix_o = out_ent_q.matrix_h;
  assign out_cxform_o = out_ent_q.cxform_h;
  assign last_o       = out_last_q;

  // --- assertions ---
  `DSDT_ASSERT(a_count_bound, count_q <= CNT_W'(ENTRIES), "entry count beyond table size")
  `DSDT_ASSERT(a_unique_match, state_q == dsdt_pkg::ST_EXEC |-> $onehot0(cell_match),
               "several cells match one depth")
  `DSDT_ASSERT(a_count_only_exec, state_q != dsdt_pkg::ST_EXEC |=> count_q == $past(count_q),
               "entry count moved outside execute")
  `DSDT_ASSERT(a_list_in_range,
               state_q == dsdt_pkg::ST_LIST && count_q != '0 |-> list_q < count_q,
               "list index ran past the entry count")

endmodule

FILE: tb/sv/dsdt_monitor.sv
// Channel monitor for the depth-sorted display table: shadow table, expected results, compare.
module dsdt_monitor #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] depth_i,
  input  logic [15:0] char_handle_i,
  input  logic [15:0] matrix_handle_i,
  input  logic [15:0] cxform_handle_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [15:0] out_depth_i,
  input  logic [15:0] out_char_i,
  input  logic [15:0] out_matrix_i,
  input  logic [15:0] out_cxform_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dsdt_pkg::status_e status;
    logic [15:0]       depth;
    logic [15:0]       char_h;
    logic [15:0]       matrix_h;
    logic [15:0]       cxform_h;
    logic              last;
  } report_t;

  logic [15:0] shadow_depth  [ENTRIES];
  logic [15:0] shadow_char   [ENTRIES];
  logic [15:0] shadow_matrix [ENTRIES];
  logic [15:0] shadow_cxform [ENTRIES];
  int          shadow_count = 0;
  report_t     due_reports[$];
  int          mismatches = 0;

  function automatic void post_report(dsdt_pkg::status_e st, logic [15:0] d, logic [15:0] c,
                                      logic [15:0] m, logic [15:0] x, logic lst);
    report_t rep;
    rep.status   = st;
    rep.depth    = d;
    rep.char_h   = c;
    rep.matrix_h = m;
    rep.cxform_h = x;
    rep.last     = lst;
    due_reports.push_back(rep);
  endfunction

  // Slot holding depth d, or shadow_count when there is none.
  function automatic int slot_of(logic [15:0] d);
    int i;
    for (i = 0; i < shadow_count; i++)
      if (shadow_depth[i] == d) return i;
    return shadow_count;
  endfunction

  function automatic void apply_place(logic [15:0] d, logic [15:0] c, logic [15:0] m,
                                      logic [15:0] x);
    int idx;
    int pos;
    int i;
    bit found;
    idx   = slot_of(d);
    found = idx < shadow_count;
    // zero handles inherit from an entry at the same depth, even with an object given
    if (found) begin
      if (c == '0) c = shadow_char[idx];
      if (m == '0) m = shadow_matrix[idx];
      if (x == '0) x = shadow_cxform[idx];
    end
    if (c == '0) begin
      post_report(dsdt_pkg::STAT_NOOBJ, d, c, m, x, 1'b1);
    end else if (found) begin
      shadow_char[idx]   = c;
      shadow_matrix[idx] = m;
      shadow_cxform[idx] = x;
      post_report(dsdt_pkg::STAT_REPLACED, d, c, m, x, 1'b1);
    end else if (shadow_count >= ENTRIES) begin
      post_report(dsdt_pkg::STAT_FULL, d, c, m, x, 1'b1);
    end else begin
      pos = 0;
      while (pos < shadow_count && shadow_depth[pos] < d) pos++;
      for (i = shadow_count; i > pos; i--) begin
        shadow_depth[i]  = shadow_depth[i-1];
        shadow_char[i]   = shadow_char[i-1];
        shadow_matrix[i] = shadow_matrix[i-1];
        shadow_cxform[i] = shadow_cxform[i-1];
      end
      shadow_depth[pos]  = d;
      shadow_char[pos]   = c;
      shadow_matrix[pos] = m;
      shadow_cxform[pos] = x;
      shadow_count++;
      post_report(dsdt_pkg::STAT_INSERTED, d, c, m, x, 1'b1);
    end
  endfunction

  function automatic void apply_remove(logic [15:0] d, logic [15:0] c);
    int idx;
    int i;
    logic [15:0] m;
    logic [15:0] x;
    idx = slot_of(d);
    if (idx >= shadow_count) begin
      post_report(dsdt_pkg::STAT_NOTFOUND, d, '0, '0, '0, 1'b1);
    end else begin
      if (c == '0) c = shadow_char[idx];
      m = shadow_matrix[idx];
      x = shadow_cxform[idx];
      for (i = idx; i + 1 < shadow_count; i++) begin
        shadow_depth[i]  = shadow_depth[i+1];
        shadow_char[i]   = shadow_char[i+1];
        shadow_matrix[i] = shadow_matrix[i+1];
        shadow_cxform[i] = shadow_cxform[i+1];
      end
      shadow_count--;
      post_report(dsdt_pkg::STAT_REMOVED, d, c, m, x, 1'b1);
    end
  endfunction

  function automatic void apply_list();
    int i;
    if (shadow_count == 0) post_report(dsdt_pkg::STAT_EMPTY, '0, '0, '0, '0, 1'b1);
    for (i = 0; i < shadow_count; i++)
      post_report(dsdt_pkg::STAT_ENTRY, shadow_depth[i], shadow_char[i], shadow_matrix[i],
                  shadow_cxform[i], i + 1 == shadow_count);
  endfunction

  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        got.status   = dsdt_pkg::status_e'(status_i);
        got.depth    = out_depth_i;
        got.char_h   = out_char_i;
        got.matrix_h = out_matrix_i;
        got.cxform_h = out_cxform_i;
        got.last     = last_i;
        if (due_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: %s d=%h c=%h m=%h x=%h last=%b",
                     got.status.name(), got.depth, got.char_h, got.matrix_h,
                     got.cxform_h, got.last);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          if (got.status !== want.status || got.depth !== want.depth ||
              got.char_h !== want.char_h || got.matrix_h !== want.matrix_h ||
              got.cxform_h !== want.cxform_h || got.last !== want.last) begin
            if (mismatches < 10)
              $display("mismatch at %0t: expected %s d=%h c=%h m=%h x=%h last=%b, %s",
                       $realtime, want.status.name(), want.depth, want.char_h,
                       want.matrix_h, want.cxform_h, want.last,
                       $sformatf("got %s d=%h c=%h m=%h x=%h last=%b",
                                 got.status.name(), got.depth, got.char_h,
                                 got.matrix_h, got.cxform_h, got.last));
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (dsdt_pkg::req_e'(req_type_i))
          dsdt_pkg::REQ_PLACE:
            apply_place(depth_i, char_handle_i, matrix_handle_i, cxform_handle_i);
          dsdt_pkg::REQ_REMOVE: apply_remove(depth_i, char_handle_i);
          dsdt_pkg::REQ_LIST:   apply_list();
          default:              ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= due_reports.size();
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the display table testbench: clock, reset, request stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 32;
  localparam int POOL = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = '0;
  logic [15:0] depth_i = '0;
  logic [15:0] char_handle_i = '0;
  logic [15:0] matrix_handle_i = '0;
  logic [15:0] cxform_handle_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] out_depth_o;
  logic [15:0] out_char_o;
  logic [15:0] out_matrix_o;
  logic [15:0] out_cxform_o;
  logic        last_o;

  int          fail_count;
  int          pending;
  int          gap_odds = 0;
  int          stall_odds = 0;
  int          stall_left = 0;
  logic [15:0] depth_pool [POOL];

  depth_sorted_display_table #(.ENTRIES(ENTRIES)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .req_type_i, .depth_i,
    .char_handle_i, .matrix_handle_i, .cxform_handle_i, .out_valid_o,
    .out_stall_i, .status_o, .out_depth_o, .out_char_o, .out_matrix_o,
    .out_cxform_o, .last_o
  );

  dsdt_monitor #(.ENTRIES(ENTRIES)) monitor (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .req_type_i, .depth_i,
    .char_handle_i, .matrix_handle_i, .cxform_handle_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .out_depth_i(out_depth_o), .out_char_i(out_char_o), .out_matrix_i(out_matrix_o),
    .out_cxform_i(out_cxform_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Hold the output in bursts; stall_odds of 0 turns the bursts off.
  always @(posedge clk_i) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
      stall_left  <= $urandom_range(1, 18);
      out_stall_i <= 1'b1;
    end
  end

  // Drive one transaction and wait for its acceptance, maybe after an idle burst.
  task automatic issue(dsdt_pkg::req_e kind, logic [15:0] d, logic [15:0] c,
                       logic [15:0] m, logic [15:0] x);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    req_type_i      <= kind;
    depth_i         <= d;
    char_handle_i   <= c;
    matrix_handle_i <= m;
    cxform_handle_i <= x;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_handle(int zero_odds);
    if ($urandom_range(1, zero_odds) == 1) return '0;
    if ($urandom_range(0, 15) == 0) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Weights are out of 100; what the three leave over goes to the unused request type.
  task automatic run_phase(int n, int place_w, int remove_w, int list_w, int gaps,
                           int stalls);
    int             done;
    int             pick;
    dsdt_pkg::req_e kind;
    logic [15:0]    d;
    done       = 0;
    gap_odds   = gaps;
    stall_odds = stalls;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      if (pick < place_w) kind = dsdt_pkg::REQ_PLACE;
      else if (pick < place_w + remove_w) kind = dsdt_pkg::REQ_REMOVE;
      else if (pick < place_w + remove_w + list_w) kind = dsdt_pkg::REQ_LIST;
      else kind = dsdt_pkg::REQ_NONE;
      d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : depth_pool[$urandom_range(0, POOL-1)];
      issue(kind, d, pick_handle(5), pick_handle(6), pick_handle(6));
      if (kind != dsdt_pkg::REQ_NONE) done++;
    end
  endtask

  initial begin
    depth_pool[0] = 16'h0000;
    depth_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL; i++) depth_pool[i] = 16'($urandom);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_odds = 3;
    issue(dsdt_pkg::REQ_LIST,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_REMOVE, 16'h1234, 16'h0000, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_PLACE,  16'h0100, 16'h0000, 16'hFFFF, 16'hFFFF);
    issue(dsdt_pkg::REQ_PLACE,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(dsdt_pkg::REQ_PLACE,  16'h0000, 16'h0001, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_PLACE,  16'h8000, 16'hAAAA, 16'h5555, 16'h00FF);
    // merge with the entry at 0x8000: inherit object and matrix
    issue(dsdt_pkg::REQ_PLACE,  16'h8000, 16'h0000, 16'h0000, 16'h1234);
    // nonzero object still inherits the zero handles
    issue(dsdt_pkg::REQ_PLACE,  16'h8000, 16'h7777, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_PLACE,  16'h4000, 16'h5A5A, 16'hA5A5, 16'hFFFF);
    issue(dsdt_pkg::REQ_LIST,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(dsdt_pkg::REQ_REMOVE, 16'h8000, 16'h0000, 16'hFFFF, 16'hFFFF);
    issue(dsdt_pkg::REQ_REMOVE, 16'h0000, 16'hBEEF, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_NONE,   16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    issue(dsdt_pkg::REQ_PLACE,  16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    issue(dsdt_pkg::REQ_LIST,   16'h0000, 16'h0000, 16'h0000, 16'h0000);

    // fill past capacity, churn, drain, then finish without idling
    run_phase(75, 80,  5, 10,  4, 6);
    run_phase(50, 45, 35, 15,  3, 3);
    run_phase(50, 15, 70, 10,  8, 0);
    run_phase(50, 50, 30, 15,  0, 5);
    run_phase(20, 45, 35, 15,  0, 0);
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: depth_sorted_display_table.f
+incdir+rtl
rtl/dsdt_pkg.sv
rtl/dsdt_cell.sv
rtl/depth_sorted_display_table.sv
tb/sv/dsdt_monitor.sv
tb/sv/tb.sv
